// ===== rtl/core/gcdm_pkg.sv =====
package gcdm_pkg;

    localparam int MAX_DIM_DEFAULT = 128;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;
    localparam logic [CFG_DATA_W-1:0] GRID_SIZE_RESET = 8'd128;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_COMPUTE = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    localparam logic [1:0] KIND_OPP = 2'd1;
    localparam logic [1:0] KIND_OWN = 2'd2;

    localparam int CELL_OPP = -1;
    localparam int CELL_OWN = -2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [6:0] cell_col;
        logic [6:0] cell_row;
        logic [1:0] cell_kind;
    } in_word_t;

    typedef struct packed {
        logic signed [8:0] cell_value;
        logic              compute_done;
    } out_word_t;

    typedef struct packed {
        logic start;
    } sweep_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sweep_status_t;

    function automatic int unsigned cell_index(input int unsigned r, input int unsigned c,
                                               input int unsigned dim);
        return r * dim + c;
    endfunction

    function automatic logic has_result(input logic [1:0] req);
        return (req == REQ_COMPUTE) || (req == REQ_READ);
    endfunction

endpackage

// ===== rtl/core/gcdm_ram.sv =====
module gcdm_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/gcdm_sweep.sv =====
module gcdm_sweep #(
    parameter int MAX_DIM = gcdm_pkg::MAX_DIM_DEFAULT
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  gcdm_pkg::sweep_ctrl_t                   ctrl,
    input  logic [$clog2(MAX_DIM+1)-1:0]            grid_w,
    input  logic [$clog2(MAX_DIM+1)-1:0]            grid_h,
    output gcdm_pkg::sweep_status_t                 status,
    output logic                                    rd_en,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      rd_addr,
    input  logic signed [$clog2(MAX_DIM+2):0]       rd_data,
    output logic                                    wr_en,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      wr_addr,
    output logic signed [$clog2(MAX_DIM+2):0]       wr_data
);

    import gcdm_pkg::*;

    localparam int RW = $clog2(MAX_DIM);
    localparam int DIM_W = $clog2(MAX_DIM+1);
    localparam int ADDR_W = $clog2(MAX_DIM*MAX_DIM);
    localparam int VAL_W = $clog2(MAX_DIM+2) + 1;

    typedef enum logic [1:0] {S_IDLE, S_CTR, S_CHK, S_NB} state_t;

    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } nb_dir_t;

    function automatic nb_dir_t nb_dir(input logic [2:0] idx);
        nb_dir_t d;
        d = '0;
        case (idx)
            3'd0: begin d.up = 1'b1; d.left = 1'b1; end
            3'd1: begin d.up = 1'b1; end
            3'd2: begin d.up = 1'b1; d.right = 1'b1; end
            3'd3: begin d.left = 1'b1; end
            3'd4: begin d.right = 1'b1; end
            3'd5: begin d.down = 1'b1; d.left = 1'b1; end
            3'd6: begin d.down = 1'b1; end
            default: begin d.down = 1'b1; d.right = 1'b1; end
        endcase
        return d;
    endfunction

    state_t             state_reg, state_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [RW-1:0]      col_reg, col_next;
    logic [DIM_W-1:0]   lv_reg, lv_next;
    logic [DIM_W-1:0]   passes_reg, passes_next;
    logic [DIM_W-1:0]   w_reg, w_next;
    logic [DIM_W-1:0]   h_reg, h_next;
    logic [2:0]         nb_reg, nb_next;
    logic               ok_reg, ok_next;
    logic               last_reg, last_next;

    logic [ADDR_W-1:0]       center_addr;
    logic [ADDR_W-1:0]       nb_addr;
    logic                    nb_ok;
    logic [2:0]              issue_idx;
    nb_dir_t                 dir;
    logic [RW-1:0]           nr;
    logic [RW-1:0]           nc;
    logic signed [VAL_W-1:0] target;
    logic signed [VAL_W-1:0] new_val;
    logic                    eligible;
    logic                    adv;
    logic                    finish;

    assign center_addr = ADDR_W'(cell_index(32'(row_reg), 32'(col_reg), MAX_DIM));
    assign target = (lv_reg == '0) ? VAL_W'(CELL_OPP) : VAL_W'(lv_reg);
    assign new_val = VAL_W'(lv_reg) + VAL_W'(1);
    assign eligible = (rd_data == '0) || ((lv_reg != '0) && (rd_data == VAL_W'(CELL_OWN)));
    assign issue_idx = (state_reg == S_CHK) ? 3'd0 : nb_reg;

    always_comb begin
        dir = nb_dir(issue_idx);
        nr = row_reg;
        nc = col_reg;
        if (dir.up) begin
            nr = row_reg - RW'(1);
        end else if (dir.down) begin
            nr = row_reg + RW'(1);
        end
        if (dir.left) begin
            nc = col_reg - RW'(1);
        end else if (dir.right) begin
            nc = col_reg + RW'(1);
        end
        nb_ok = !(dir.up && (row_reg == '0)) &&
                !(dir.down && ((DIM_W'(row_reg) + DIM_W'(1)) >= h_reg)) &&
                !(dir.left && (col_reg == '0)) &&
                !(dir.right && ((DIM_W'(col_reg) + DIM_W'(1)) >= w_reg));
        nb_addr = nb_ok ? ADDR_W'(cell_index(32'(nr), 32'(nc), MAX_DIM)) : center_addr;
    end

    always_comb begin
        state_next = state_reg;
        row_next = row_reg;
        col_next = col_reg;
        lv_next = lv_reg;
        passes_next = passes_reg;
        w_next = w_reg;
        h_next = h_reg;
        nb_next = nb_reg;
        ok_next = ok_reg;
        last_next = last_reg;
        rd_en = 1'b0;
        rd_addr = center_addr;
        wr_en = 1'b0;
        wr_addr = center_addr;
        wr_data = new_val;
        adv = 1'b0;
        finish = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (ctrl.start) begin
                    w_next = grid_w;
                    h_next = grid_h;
                    passes_next = (grid_w > grid_h) ? grid_w : grid_h;
                    row_next = '0;
                    col_next = '0;
                    lv_next = '0;
                    state_next = S_CTR;
                end
            end
            S_CTR: begin
                rd_en = 1'b1;
                state_next = S_CHK;
            end
            S_CHK: begin
                if (eligible) begin
                    rd_en = 1'b1;
                    rd_addr = nb_addr;
                    ok_next = nb_ok;
                    nb_next = 3'd1;
                    last_next = 1'b0;
                    state_next = S_NB;
                end else begin
                    adv = 1'b1;
                end
            end
            S_NB: begin
                if (ok_reg && (rd_data == target)) begin
                    wr_en = 1'b1;
                    adv = 1'b1;
                end else if (last_reg) begin
                    adv = 1'b1;
                end else begin
                    rd_en = 1'b1;
                    rd_addr = nb_addr;
                    ok_next = nb_ok;
                    nb_next = nb_reg + 3'd1;
                    last_next = (nb_reg == 3'd7);
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (adv) begin
            state_next = S_CTR;
            if ((DIM_W'(col_reg) + DIM_W'(1)) < w_reg) begin
                col_next = col_reg + RW'(1);
            end else begin
                col_next = '0;
                if ((DIM_W'(row_reg) + DIM_W'(1)) < h_reg) begin
                    row_next = row_reg + RW'(1);
                end else begin
                    row_next = '0;
                    if (lv_reg == passes_reg) begin
                        finish = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        lv_next = lv_reg + DIM_W'(1);
                    end
                end
            end
        end
    end

    assign status.busy = (state_reg != S_IDLE);
    assign status.done = finish;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        row_reg <= row_next;
        col_reg <= col_next;
        lv_reg <= lv_next;
        passes_reg <= passes_next;
        w_reg <= w_next;
        h_reg <= h_next;
        nb_reg <= nb_next;
        ok_reg <= ok_next;
        last_reg <= last_next;
    end

    a_write_only_on_match: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == S_NB) && ok_reg && (rd_data == target))
        else $error("sweep write without a matching neighbor");

    a_check_follows_center: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CTR) |=> (state_reg == S_CHK))
        else $error("center read not followed by check");

    a_level_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> (lv_reg <= passes_reg))
        else $error("sweep level beyond pass count");

endmodule

// ===== rtl/core/grid_chebyshev_distance_map.sv =====
// grid distance map: chessboard distance from opponent cells over a loaded grid
// input channel s_valid/s_ready/s_word carries one request word: load a cell,
// compute the map, or read a cell. result channel m_valid/m_ready/m_word
// carries one word per compute or read; a load gives none.
// cfg_we/cfg_index/cfg_wdata write grid width (index 0) and height (index 1),
// both 128 after reset; write them only while the block is idle.
// a load is taken while idle and the next word may follow at once.
// a read gives its result through the registered ram read and then the output register.
// a compute sweeps the active grid max(width,height)+1 times through the single
// ram read port: a cell that cannot change takes a center read and a check, a
// candidate cell also up to eight neighbor reads, stopping at a match.
// the result word follows the last sweep; no request is taken meanwhile.
// reset (aresetn, synchronous, active low) clears control state and sets the size
// registers to 128; cell contents are undefined until loaded, with no clearing pass.
// when m_ready is low the result word waits in the output register; loads are
// still taken, reads and computes wait until the output register frees up.
module grid_chebyshev_distance_map #(
    parameter int MAX_DIM = gcdm_pkg::MAX_DIM_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [gcdm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gcdm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  gcdm_pkg::in_word_t                 s_word,
    output logic                               m_valid,
    input  logic                               m_ready,
    output gcdm_pkg::out_word_t                m_word
);

    import gcdm_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM+1);
    localparam int ADDR_W = $clog2(MAX_DIM*MAX_DIM);
    localparam int VAL_W = $clog2(MAX_DIM+2) + 1;
    localparam int DEPTH = MAX_DIM * MAX_DIM;

    typedef enum logic [1:0] {T_IDLE, T_READ, T_SWEEP} state_t;

    state_t                  st_reg, st_next;
    logic [CFG_DATA_W-1:0]   width_reg, width_next;
    logic [CFG_DATA_W-1:0]   height_reg, height_next;
    logic                    m_valid_reg, m_valid_next;
    out_word_t               m_word_reg, m_word_next;
    logic                    inside_reg, inside_next;

    logic [DIM_W-1:0]        w_eff;
    logic [DIM_W-1:0]        h_eff;
    logic                    accept;
    logic                    in_grid;
    logic [ADDR_W-1:0]       req_addr;
    logic signed [VAL_W-1:0] load_val;
    logic                    load_we;

    sweep_ctrl_t             sweep_ctrl;
    sweep_status_t           sweep_sts;
    logic                    sw_rd_en;
    logic [ADDR_W-1:0]       sw_rd_addr;
    logic                    sw_wr_en;
    logic [ADDR_W-1:0]       sw_wr_addr;
    logic signed [VAL_W-1:0] sw_wr_data;

    logic                    ram_rd_en;
    logic [ADDR_W-1:0]       ram_rd_addr;
    logic                    ram_wr_en;
    logic [ADDR_W-1:0]       ram_wr_addr;
    logic [VAL_W-1:0]        ram_wr_data;
    logic [VAL_W-1:0]        ram_rd_data;
    logic signed [VAL_W-1:0] rd_val;

    assign w_eff = (32'(width_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(width_reg);
    assign h_eff = (32'(height_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(height_reg);

    assign s_ready = (st_reg == T_IDLE) &&
                     (!has_result(s_word.req_type) || !m_valid_reg || m_ready);
    assign accept = s_valid && s_ready;

    assign in_grid = (32'(s_word.cell_col) < MAX_DIM) && (32'(s_word.cell_row) < MAX_DIM);
    assign req_addr = ADDR_W'(cell_index(32'(s_word.cell_row), 32'(s_word.cell_col),
                                         MAX_DIM));

    always_comb begin
        case (s_word.cell_kind)
            KIND_OPP: load_val = VAL_W'(CELL_OPP);
            KIND_OWN: load_val = VAL_W'(CELL_OWN);
            default:  load_val = '0;
        endcase
    end

    assign load_we = accept && (s_word.req_type == REQ_LOAD) && in_grid;

    assign ram_wr_en = (st_reg == T_SWEEP) ? sw_wr_en : load_we;
    assign ram_wr_addr = (st_reg == T_SWEEP) ? sw_wr_addr : req_addr;
    assign ram_wr_data = (st_reg == T_SWEEP) ? sw_wr_data : load_val;
    assign ram_rd_en = (st_reg == T_SWEEP) ? sw_rd_en :
                       (accept && (s_word.req_type == REQ_READ));
    assign ram_rd_addr = (st_reg == T_SWEEP) ? sw_rd_addr : req_addr;
    assign rd_val = ram_rd_data;

    assign sweep_ctrl.start = accept && (s_word.req_type == REQ_COMPUTE) &&
                              (w_eff != '0) && (h_eff != '0);

    gcdm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    gcdm_sweep #(
        .MAX_DIM (MAX_DIM)
    ) u_sweep (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (sweep_ctrl),
        .grid_w  (w_eff),
        .grid_h  (h_eff),
        .status  (sweep_sts),
        .rd_en   (sw_rd_en),
        .rd_addr (sw_rd_addr),
        .rd_data (rd_val),
        .wr_en   (sw_wr_en),
        .wr_addr (sw_wr_addr),
        .wr_data (sw_wr_data)
    );

    always_comb begin
        st_next = st_reg;
        width_next = width_reg;
        height_next = height_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_word_next = m_word_reg;
        inside_next = inside_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_GRID_WIDTH:  width_next = cfg_wdata;
                CFG_GRID_HEIGHT: height_next = cfg_wdata;
                default: ;
            endcase
        end
        case (st_reg)
            T_IDLE: begin
                if (accept) begin
                    case (s_word.req_type)
                        REQ_READ: begin
                            inside_next = in_grid;
                            st_next = T_READ;
                        end
                        REQ_COMPUTE: begin
                            if (sweep_ctrl.start) begin
                                st_next = T_SWEEP;
                            end else begin
                                m_valid_next = 1'b1;
                                m_word_next.cell_value = '0;
                                m_word_next.compute_done = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            T_READ: begin
                m_valid_next = 1'b1;
                m_word_next.cell_value = inside_reg ? 9'(rd_val) : '0;
                m_word_next.compute_done = 1'b0;
                st_next = T_IDLE;
            end
            T_SWEEP: begin
                if (sweep_sts.done) begin
                    m_valid_next = 1'b1;
                    m_word_next.cell_value = '0;
                    m_word_next.compute_done = 1'b1;
                    st_next = T_IDLE;
                end
            end
            default: begin
                st_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= T_IDLE;
            width_reg <= GRID_SIZE_RESET;
            height_reg <= GRID_SIZE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            width_reg <= width_next;
            height_reg <= height_next;
            m_valid_reg <= m_valid_next;
        end
        m_word_reg <= m_word_next;
        inside_reg <= inside_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word = m_word_reg;

    a_sweep_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == T_SWEEP) == sweep_sts.busy)
        else $error("sweep engine and top state disagree");

    a_done_only_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        sweep_sts.done |-> (st_reg == T_SWEEP))
        else $error("sweep done outside a compute");

    a_read_gives_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == T_READ) |=> m_valid_reg && !m_word_reg.compute_done)
        else $error("read did not produce a result word");

    a_no_load_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != T_IDLE) |-> !load_we && !sweep_ctrl.start)
        else $error("request taken while busy");

endmodule
